### rtl/btt_pkg.sv
// Package for the branch target table: payload structs, op and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package btt_pkg;

   localparam logic [1:0] OP_LOOKUP   = 2'd0;
   localparam logic [1:0] OP_CREATE   = 2'd1;
   localparam logic [1:0] OP_PATCH    = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISS    = 2'd1;
   localparam logic [1:0] ST_NOMEM   = 2'd2;
   localparam logic [1:0] ST_INVALID = 2'd3;

   localparam int STUB_BYTES = 14;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] guest_addr;
      logic [63:0] host_target;
      logic [5:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  result_index;
      logic [63:0] stub_address;
      logic [63:0] entry_target;
      logic [31:0] entry_hits;
      logic        entry_patched;
      logic        evicted;
   } rsp_type;

   // per-cell contents that circulate through the ring
   typedef struct packed {
      logic [63:0] key;
      logic [63:0] target;
      logic [31:0] hits;
      logic        patched;
      logic [19:0] stub_off;
      logic        stub_ok;
   } entry_type;

endpackage
`default_nettype wire

### rtl/btt_cell.sv
// One slot of the circulating entry ring; holds an entry and passes it on.
// Depends on btt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btt_cell (
   input  wire logic               clock,
   input  wire logic               shift,
   input  wire btt_pkg::entry_type d_in,
   output btt_pkg::entry_type      d_out
);
   import btt_pkg::*;

   entry_type data_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= d_in;
      end
   end

   assign d_out = data_ff;
endmodule
`default_nettype wire

### rtl/branch_target_table_lfu.sv
// Branch target table top level; depends on btt_pkg and btt_cell.
// Flow: an accepted request is scanned over one full ring rotation, then the response is registered;
//   a create that allocates a slot needs a second ring rotation before it responds.
// One transaction at a time: busy stays high for the rotations, and start is taken only
//   while idle. The receiver cannot stall.
// Reset clears fill count, stub allocator and stub_base; slots are undefined until filled.
`timescale 1ns / 1ps
`default_nettype none
module branch_target_table_lfu #(
   parameter int ENTRIES = 64,
   parameter int STUB_MEMORY_BYTES = 1048576
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire btt_pkg::req_type req_data,
   output logic                  rsp_valid,
   output btt_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [63:0]      csr_wdata
);
   import btt_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int UW = $clog2(STUB_MEMORY_BYTES + STUB_BYTES + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DONE  = 2'd2;
   localparam logic [1:0] S_ALLOC = 2'd3;

   logic [1:0]    state_ff;
   logic [63:0]   base_ff;
   logic [CW-1:0] fill_ff;
   logic [UW-1:0] used_ff;
   req_type       req_ff;
   logic [IW-1:0] pos_ff;
   logic          found_ff;
   logic [IW-1:0] fidx_ff;
   logic [IW-1:0] midx_ff;
   logic [31:0]   mhits_ff;
   logic          fvalid_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rv_ff;
   logic          alloc_ff;
   logic [IW-1:0] aidx_ff;
   logic          ev_ff;
   logic          nomem_ff;
   logic [19:0]   aoff_ff;

   entry_type ring [ENTRIES];
   entry_type head, head_new, sel_ff;
   logic      shift;

   // ring: cell 0 is the head; its output feeds cell ENTRIES-1 (after edit)
   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         entry_type din;
         if (g == ENTRIES - 1) begin : g_wrap
            assign din = head_new;
         end else begin : g_pass
            assign din = ring[g + 1];
         end
         btt_cell u_cell (.clock(clock), .shift(shift), .d_in(din), .d_out(ring[g]));
      end
   endgenerate

   assign head  = ring[0];
   assign shift = (state_ff == S_SCAN) || (state_ff == S_ALLOC);

   logic [CW-1:0] pos_ext;
   logic          slot_filled, hit_here, patch_here, patch_ok;
   logic          full, nomem, last_pos, alloc_go, respond;
   assign pos_ext     = CW'(pos_ff);
   assign slot_filled = pos_ext < fill_ff;
   assign hit_here    = state_ff == S_SCAN && slot_filled && !found_ff
                        && head.key == req_ff.guest_addr
                        && (req_ff.op == OP_LOOKUP
                            || (req_ff.op == OP_CREATE && req_ff.host_target != 64'd0));
   assign patch_here  = state_ff == S_SCAN && req_ff.op == OP_PATCH
                        && 32'(req_ff.entry_index) == 32'(pos_ff);
   assign patch_ok    = slot_filled && head.stub_ok && req_ff.host_target != 64'd0;
   assign full        = fill_ff == CW'(ENTRIES);
   assign nomem       = (used_ff + UW'(STUB_BYTES)) > UW'(STUB_MEMORY_BYTES);
   assign last_pos    = pos_ff == IW'(ENTRIES - 1);
   // a create that missed needs a second rotation to write the new slot
   assign alloc_go    = state_ff == S_DONE && !alloc_ff && req_ff.op == OP_CREATE
                        && req_ff.host_target != 64'd0 && !found_ff;
   assign respond     = state_ff == S_DONE && !alloc_go;

   function automatic rsp_type mk(input logic [1:0] st, input logic [IW-1:0] ix,
                                  input entry_type e, input logic ev,
                                  input logic [63:0] base);
      rsp_type r;
      r.status        = st;
      r.result_index  = 6'(ix);
      r.stub_address  = e.stub_ok ? base + 64'(e.stub_off) : 64'd0;
      r.entry_target  = e.target;
      r.entry_hits    = e.hits;
      r.entry_patched = e.patched;
      r.evicted       = ev;
      return r;
   endfunction

   // per-step edit of the head entry (hit counting, update, patch, allocation)
   always_comb begin
      head_new = head;
      if (state_ff == S_ALLOC) begin
         if (pos_ff == aidx_ff) begin
            head_new.key     = req_ff.guest_addr;
            head_new.target  = req_ff.host_target;
            head_new.hits    = 32'd0;
            head_new.patched = 1'b0;
            if (!nomem_ff) begin
               head_new.stub_off = aoff_ff;
               head_new.stub_ok  = 1'b1;
            end else if (!ev_ff) begin
               head_new.stub_ok = 1'b0;
            end
         end
      end else begin
         if (hit_here) begin
            if (head.hits != 32'hFFFF_FFFF) head_new.hits = head.hits + 32'd1;
            if (req_ff.op == OP_CREATE) head_new.target = req_ff.host_target;
         end
         if (patch_here && patch_ok) begin
            head_new.target  = req_ff.host_target;
            head_new.patched = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      if (alloc_ff) begin
         rsp_in = mk(nomem_ff ? ST_NOMEM : ST_OK, aidx_ff, sel_ff, ev_ff, base_ff);
      end else begin
         unique case (req_ff.op)
            OP_LOOKUP: begin
               if (found_ff) rsp_in = mk(ST_OK, fidx_ff, sel_ff, 1'b0, base_ff);
               else rsp_in.status = ST_MISS;
            end
            OP_CREATE: begin
               if (found_ff) rsp_in = mk(ST_OK, fidx_ff, sel_ff, 1'b0, base_ff);
               else rsp_in.status = ST_INVALID;
            end
            OP_PATCH: begin
               if (fvalid_ff) rsp_in = mk(ST_OK, fidx_ff, sel_ff, 1'b0, base_ff);
               else rsp_in.status = ST_INVALID;
            end
            default: rsp_in.status = ST_INVALID;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff  <= 64'd0;
         fill_ff  <= '0;
         used_ff  <= '0;
         rv_ff    <= 1'b0;
         alloc_ff <= 1'b0;
      end else begin
         rv_ff    <= respond;
         alloc_ff <= state_ff == S_ALLOC;
         if (csr_we) base_ff <= csr_wdata;
         if (respond) rsp_ff <= rsp_in;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff    <= req_data;
                  pos_ff    <= '0;
                  found_ff  <= 1'b0;
                  fvalid_ff <= 1'b0;
                  mhits_ff  <= 32'hFFFF_FFFF;
                  midx_ff   <= '0;
                  state_ff  <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (hit_here) found_ff <= 1'b1;
               if (patch_here) fvalid_ff <= patch_ok;
               if (hit_here || patch_here) begin
                  fidx_ff <= pos_ff;
                  sel_ff  <= head_new;
               end
               // least-hit slot, lowest index on ties
               if (slot_filled && (pos_ff == '0 || head.hits < mhits_ff)) begin
                  mhits_ff <= head.hits;
                  midx_ff  <= pos_ff;
               end
               pos_ff <= pos_ff + 1'b1;
               if (last_pos) state_ff <= S_DONE;
            end
            S_DONE: begin
               if (alloc_go) begin
                  aidx_ff  <= full ? midx_ff : IW'(fill_ff);
                  ev_ff    <= full;
                  nomem_ff <= nomem;
                  aoff_ff  <= 20'(used_ff);
                  if (!full) fill_ff <= fill_ff + CW'(1);
                  if (!nomem) used_ff <= used_ff + UW'(STUB_BYTES);
                  pos_ff   <= '0;
                  state_ff <= S_ALLOC;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_ALLOC: begin
               if (pos_ff == aidx_ff) sel_ff <= head_new;
               pos_ff <= pos_ff + 1'b1;
               if (last_pos) state_ff <= S_DONE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid);
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy);
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy);
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(ENTRIES));
`endif
endmodule
`default_nettype wire
